[rtl/pidpc_pkg.sv]
// pidpc_pkg: shared types and constants for the pid position controller
// fixed field widths, register indexes, reset values, multiplier control struct
// no dependencies

package pidpc_pkg;

  // fixed field widths
  localparam int GAIN_W     = 32;
  localparam int DT_W       = 32;
  localparam int LIMIT_W    = 31;
  localparam int TIME_FRAC  = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // shared multiplier: 33 x 33 signed, operand b taken in 32-bit digits
  localparam int DIG_W  = 32;
  localparam int OPA_W  = 33;
  localparam int PP_W   = 66;

  // internal term bound +-2^61, terms carried in 63 signed bits
  localparam int TERM_W = 63;
  localparam logic signed [TERM_W-1:0] TERM_LIMIT = {2'b01, {(TERM_W-2){1'b0}}};

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KI  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KD  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LIM = 2'd3;

  // register reset values
  localparam logic [GAIN_W-1:0]  KP_RST  = 32'd13107200;
  localparam logic [GAIN_W-1:0]  KI_RST  = 32'd1310720;
  localparam logic [GAIN_W-1:0]  KD_RST  = 32'd1310720;
  localparam logic [LIMIT_W-1:0] LIM_RST = 31'd26214;

  // multiplier control from the sequencer
  typedef struct packed {
    logic clr;  // clear accumulator
    logic mul;  // capture a new partial product
    logic acc;  // add captured partial product into accumulator
    logic hi;   // partial product being captured belongs to the upper digit
  } mac_ctl_t;

endpackage

[rtl/pidpc_div.sv]
// pidpc_div: bit-serial restoring divider, one quotient bit per cycle
// unsigned numerator of NUM_W bits over a 32-bit divisor
// depends on pidpc_pkg

module pidpc_div #(
  parameter int NUM_W = 57
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start_i,
  input  logic [NUM_W-1:0]              num_i,
  input  logic [pidpc_pkg::DT_W-1:0]    den_i,
  output logic                          busy_o,
  output logic [NUM_W-1:0]              quo_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);
  localparam int DW    = pidpc_pkg::DT_W;

  logic             busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DW-1:0]    rem_r;
  logic [DW-1:0]    den_r;
  logic [NUM_W-1:0] sh_r;

  logic [DW:0] trial;
  logic [DW:0] diff;
  logic        fits;

  // one restoring step: bring down the next numerator bit, try to subtract
  assign trial = {rem_r, sh_r[NUM_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign fits  = (trial >= {1'b0, den_r});

  // step counter and busy flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start_i) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(NUM_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // remainder and numerator/quotient shift register
  always_ff @(posedge clk) begin
    if (start_i) begin
      rem_r <= '0;
      sh_r  <= num_i;
      den_r <= den_i;
    end else if (busy_r) begin
      rem_r <= fits ? diff[DW-1:0] : trial[DW-1:0];
      sh_r  <= {sh_r[NUM_W-2:0], fits};
    end
  end

  assign busy_o = busy_r;
  assign quo_o  = sh_r;

  // checks
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start_i |=> busy_r)
    else $error("divider not busy after start");

  a_busy_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (cnt_r != '0))
    else $error("divider busy with no steps left");

endmodule

[rtl/pidpc_mac.sv]
// pidpc_mac: shared signed multiply-accumulate unit
// one 33x33 product per cycle while mul is set, registered, then added at a digit offset
// depends on pidpc_pkg

module pidpc_mac #(
  parameter int ACC_W = 96
) (
  input  logic                                  clk,
  input  pidpc_pkg::mac_ctl_t                   ctl_i,
  input  logic signed [pidpc_pkg::OPA_W-1:0]    a_i,
  input  logic signed [pidpc_pkg::OPA_W-1:0]    d_i,
  output logic signed [ACC_W-1:0]               acc_o
);

  logic signed [pidpc_pkg::PP_W-1:0] pp_nxt;
  logic signed [pidpc_pkg::PP_W-1:0] pp_r;
  logic                              hi_r;
  logic signed [ACC_W-1:0]           addend;
  logic signed [ACC_W-1:0]           acc_r;

  // partial product of the full operand a and one digit of b
  assign pp_nxt = a_i * d_i;

  // upper digit lands one digit width higher
  assign addend = hi_r ? (ACC_W'(pp_r) <<< pidpc_pkg::DIG_W) : ACC_W'(pp_r);

  // product register
  always_ff @(posedge clk) begin
    if (ctl_i.mul) begin
      pp_r <= pp_nxt;
      hi_r <= ctl_i.hi;
    end
  end

  // accumulator
  always_ff @(posedge clk) begin
    if (ctl_i.clr) begin
      acc_r <= '0;
    end else if (ctl_i.acc) begin
      acc_r <= acc_r + addend;
    end
  end

  assign acc_o = acc_r;

endmodule

[rtl/pid_position_controller_top.sv]
// pid_position_controller_top: pid position controller with anti-windup and
// derivative on measurement, sequenced over a shared multiplier and a divider
// depends on pidpc_pkg, pidpc_div, pidpc_mac
//
// usage
//   input channel: in_valid / in_stall with time step (unsigned Q8.24 s),
//   setpoint and measurement (signed, FRAC_BITS fraction bits). an item is
//   taken when in_valid is high and in_stall is low.
//   result channel: out_valid / out_stall with drive, drive_saturated and
//   step_was_zero; a result is taken when out_valid is high and out_stall low.
//   configuration: cfg_we / cfg_index / cfg_wdata write kp, ki, kd and the
//   integral limit; write only while no item is in flight.
// sequencing
//   one item at a time; in_stall stays high from acceptance until the result
//   is loaded into the output register. the derivative term waits for the
//   bit-serial divider, which runs one quotient bit per cycle while the
//   shared multiplier works the integral, p and i terms in turn.
// reset and stall
//   reset loads the default gains and limit, clears integral and previous
//   measurement and drops out_valid. a held result stays stable under
//   out_stall; the next item may be accepted meanwhile, and its result waits
//   for the output register to empty.

module pid_position_controller_top #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration
  input  logic                                cfg_we,
  input  logic [pidpc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pidpc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [pidpc_pkg::DT_W-1:0]          in_time_step,
  input  logic signed [WORD_BITS-1:0]         in_setpoint,
  input  logic signed [WORD_BITS-1:0]         in_measurement,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [WORD_BITS-1:0]         out_drive,
  output logic                                out_drive_saturated,
  output logic                                out_step_was_zero
);

  localparam int E_W    = WORD_BITS + 1;
  localparam int NUM_W  = E_W + pidpc_pkg::TIME_FRAC;
  localparam int BW     = (E_W > pidpc_pkg::TERM_W) ? E_W : pidpc_pkg::TERM_W;
  localparam int ACC_W  = pidpc_pkg::OPA_W + BW;
  localparam int QX_W   = (NUM_W > pidpc_pkg::TERM_W) ? NUM_W : pidpc_pkg::TERM_W;
  localparam int ISUM_W = pidpc_pkg::TERM_W + 1;
  localparam int SUM_W  = pidpc_pkg::TERM_W + 2;
  localparam int GW     = pidpc_pkg::GAIN_W;
  localparam int TW     = pidpc_pkg::TERM_W;

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  // products worked by the shared multiplier
  localparam logic [1:0] OP_INC = 2'd0;
  localparam logic [1:0] OP_P   = 2'd1;
  localparam logic [1:0] OP_I   = 2'd2;
  localparam logic [1:0] OP_D   = 2'd3;

  // control state
  logic [1:0] state_r;
  logic [1:0] op_r;
  logic [1:0] ph_r;
  logic       out_valid_r;

  // configuration registers
  logic signed [GW-1:0]                    kp_r;
  logic signed [GW-1:0]                    ki_r;
  logic signed [GW-1:0]                    kd_r;
  logic [pidpc_pkg::LIMIT_W-1:0]           lim_r;

  // controller state
  logic signed [GW-1:0]        integ_r;
  logic signed [WORD_BITS-1:0] prev_r;

  // per-item working registers
  logic [pidpc_pkg::DT_W-1:0]  dt_r;
  logic signed [E_W-1:0]       e_r;
  logic                        dpos_r;
  logic                        zero_r;
  logic signed [TW-1:0]        de_r;
  logic signed [SUM_W-1:0]     sum_r;

  // output registers
  logic signed [WORD_BITS-1:0] drive_r;
  logic                        sat_r;
  logic                        zflag_r;

  logic                        accept;
  logic                        load;
  logic signed [E_W-1:0]       e_in;
  logic signed [E_W-1:0]       delta;
  logic [E_W-1:0]              dmag;
  logic [NUM_W-1:0]            div_num;
  logic                        div_busy;
  logic [NUM_W-1:0]            div_quo;

  pidpc_pkg::mac_ctl_t                   mac_ctl;
  logic signed [pidpc_pkg::OPA_W-1:0]    mac_a;
  logic signed [pidpc_pkg::OPA_W-1:0]    mac_d;
  logic signed [BW-1:0]                  mac_b;
  logic signed [ACC_W-1:0]               mac_acc;

  logic signed [ACC_W-1:0]     shifted;
  logic signed [ACC_W-1:0]     tl_x;
  logic signed [ACC_W-1:0]     ntl_x;
  logic signed [TW-1:0]        term;
  logic signed [ISUM_W-1:0]    isum;
  logic signed [ISUM_W-1:0]    lim_x;
  logic signed [ISUM_W-1:0]    nlim_x;
  logic signed [GW-1:0]        integ_nxt;
  logic [QX_W-1:0]             q_x;
  logic [QX_W-1:0]             qtl_x;
  logic signed [TW-1:0]        q_sat;
  logic signed [TW-1:0]        de_nxt;
  logic signed [SUM_W-1:0]     drv_max;
  logic signed [SUM_W-1:0]     drv_min;
  logic signed [WORD_BITS-1:0] drive_nxt;
  logic                        sat_nxt;

  // handshake
  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && (state_r == ST_IDLE);
  assign load     = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  // error and measurement change of the incoming item
  assign e_in    = E_W'(in_setpoint) - E_W'(in_measurement);
  assign delta   = E_W'(in_measurement) - E_W'(prev_r);
  assign dmag    = delta[E_W-1] ? E_W'(-delta) : E_W'(delta);
  assign div_num = {dmag, {pidpc_pkg::TIME_FRAC{1'b0}}};

  // |delta| * 2^24 / time_step
  pidpc_div #(
    .NUM_W (NUM_W)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (accept),
    .num_i   (div_num),
    .den_i   (in_time_step),
    .busy_o  (div_busy),
    .quo_o   (div_quo)
  );

  // operand selection for the shared multiplier
  always_comb begin
    case (op_r)
      OP_INC: begin
        mac_a = {1'b0, dt_r};
        mac_b = BW'(e_r);
      end
      OP_P: begin
        mac_a = pidpc_pkg::OPA_W'(kp_r);
        mac_b = BW'(e_r);
      end
      OP_I: begin
        mac_a = pidpc_pkg::OPA_W'(ki_r);
        mac_b = BW'(integ_r);
      end
      default: begin
        mac_a = pidpc_pkg::OPA_W'(kd_r);
        mac_b = BW'(de_r);
      end
    endcase
  end

  // low digit unsigned, upper digit carries the sign
  assign mac_d = (ph_r == 2'd0) ? {1'b0, mac_b[pidpc_pkg::DIG_W-1:0]}
                                : pidpc_pkg::OPA_W'($signed(mac_b[BW-1:pidpc_pkg::DIG_W]));

  // multiplier phases: 0 clear + low product, 1 add + high product, 2 add, 3 read
  always_comb begin
    mac_ctl.clr = (state_r == ST_MUL) && (ph_r == 2'd0);
    mac_ctl.mul = (state_r == ST_MUL) && ((ph_r == 2'd0) || (ph_r == 2'd1));
    mac_ctl.acc = (state_r == ST_MUL) && ((ph_r == 2'd1) || (ph_r == 2'd2));
    mac_ctl.hi  = (ph_r == 2'd1);
  end

  pidpc_mac #(
    .ACC_W (ACC_W)
  ) u_mac (
    .clk   (clk),
    .ctl_i (mac_ctl),
    .a_i   (mac_a),
    .d_i   (mac_d),
    .acc_o (mac_acc)
  );

  // floor shift of the exact product, then bound to +-2^61
  assign shifted = (op_r == OP_INC) ? (mac_acc >>> pidpc_pkg::TIME_FRAC)
                                    : (mac_acc >>> FRAC_BITS);
  assign tl_x    = ACC_W'(pidpc_pkg::TERM_LIMIT);
  assign ntl_x   = -tl_x;

  always_comb begin
    if (shifted > tl_x) begin
      term = pidpc_pkg::TERM_LIMIT;
    end else if (shifted < ntl_x) begin
      term = -pidpc_pkg::TERM_LIMIT;
    end else begin
      term = shifted[TW-1:0];
    end
  end

  // integral update with anti-windup clamp
  assign isum   = ISUM_W'(integ_r) + ISUM_W'(term);
  assign lim_x  = ISUM_W'(lim_r);
  assign nlim_x = -lim_x;

  always_comb begin
    if (isum > lim_x) begin
      integ_nxt = lim_x[GW-1:0];
    end else if (isum < nlim_x) begin
      integ_nxt = nlim_x[GW-1:0];
    end else begin
      integ_nxt = isum[GW-1:0];
    end
  end

  // derivative from the quotient: bound, then negate for a rising measurement; zero for a zero time step
  assign q_x   = QX_W'(div_quo);
  assign qtl_x = QX_W'(pidpc_pkg::TERM_LIMIT);
  assign q_sat = (q_x > qtl_x) ? pidpc_pkg::TERM_LIMIT : q_x[TW-1:0];

  always_comb begin
    if (zero_r) begin
      de_nxt = '0;
    end else if (dpos_r) begin
      de_nxt = -q_sat;
    end else begin
      de_nxt = q_sat;
    end
  end

  // drive saturation to the word range
  assign drv_max = {{(SUM_W-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
  assign drv_min = ~drv_max;

  always_comb begin
    sat_nxt = 1'b1;
    if (sum_r > drv_max) begin
      drive_nxt = drv_max[WORD_BITS-1:0];
    end else if (sum_r < drv_min) begin
      drive_nxt = drv_min[WORD_BITS-1:0];
    end else begin
      drive_nxt = sum_r[WORD_BITS-1:0];
      sat_nxt   = 1'b0;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r  <= pidpc_pkg::KP_RST;
      ki_r  <= pidpc_pkg::KI_RST;
      kd_r  <= pidpc_pkg::KD_RST;
      lim_r <= pidpc_pkg::LIM_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        pidpc_pkg::CFG_KP:  kp_r  <= cfg_wdata;
        pidpc_pkg::CFG_KI:  ki_r  <= cfg_wdata;
        pidpc_pkg::CFG_KD:  kd_r  <= cfg_wdata;
        pidpc_pkg::CFG_LIM: lim_r <= cfg_wdata[pidpc_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and controller state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      op_r    <= OP_INC;
      ph_r    <= 2'd0;
      integ_r <= '0;
      prev_r  <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            prev_r  <= in_measurement;
            op_r    <= OP_INC;
            ph_r    <= 2'd0;
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          ph_r <= ph_r + 2'd1;
          if (ph_r == 2'd3) begin
            case (op_r)
              OP_INC: begin
                integ_r <= integ_nxt;
                op_r    <= OP_P;
              end
              OP_P: op_r <= OP_I;
              OP_I: state_r <= ST_WAIT;
              default: state_r <= ST_DONE;
            endcase
          end
        end
        ST_WAIT: begin
          if (!div_busy) begin
            op_r    <= OP_D;
            ph_r    <= 2'd0;
            state_r <= ST_MUL;
          end
        end
        default: begin
          if (load) begin
            state_r <= ST_IDLE;
          end
        end
      endcase
    end
  end

  // per-item working registers
  always_ff @(posedge clk) begin
    if (accept) begin
      dt_r   <= in_time_step;
      e_r    <= e_in;
      dpos_r <= !delta[E_W-1] && (delta != '0);
      zero_r <= (in_time_step == '0);
      sum_r  <= '0;
    end else if ((state_r == ST_MUL) && (ph_r == 2'd3) && (op_r != OP_INC)) begin
      sum_r <= sum_r + SUM_W'(term);
    end
    if ((state_r == ST_WAIT) && !div_busy) begin
      de_r <= de_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      drive_r <= drive_nxt;
      sat_r   <= sat_nxt;
      zflag_r <= zero_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_drive           = drive_r;
  assign out_drive_saturated = sat_r;
  assign out_step_was_zero   = zflag_r;

  // checks
  a_accept_stall: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> in_stall)
    else $error("input not stalled after an item was taken");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_DONE))
    else $error("result raised outside the done state");

  a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && sat_r) |->
      ((drive_r == drv_max[WORD_BITS-1:0]) || (drive_r == drv_min[WORD_BITS-1:0])))
    else $error("saturation flag without a bound drive");

  a_div_ready: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_MUL) && (op_r == OP_D)) |-> !div_busy)
    else $error("derivative term started before the quotient was ready");

endmodule
